>>> design/gost_cfb_block_cipher_macros.svh
// Assertion shorthands for the GOST CFB block checker.
// Each macro samples on the rising edge of clock and is idle while reset is high.
`ifndef GOST_CFB_BLOCK_CIPHER_MACROS_SVH
`define GOST_CFB_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication.
`define GCFB_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GCFB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/gcfb_pkg.sv
`timescale 1ns / 1ps

package gcfb_pkg;

   localparam int BLOCK_W   = 64;
   localparam int HALF_W    = 32;
   localparam int BYTES     = 8;
   localparam int CNT_W     = 4;
   localparam int ROUNDS    = 32;
   localparam int ROUND_W   = $clog2(ROUNDS);
   localparam int REV_START = ROUNDS - 8;
   localparam int ROT_BITS  = 11;
   localparam int KIDX_W    = 3;
   localparam int KEY_REGS  = 4;
   localparam int ADDR_W    = 6;
   localparam int REG_SEL_W = 3;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_KEY01 = 3'd0,
      REG_KEY23 = 3'd1,
      REG_KEY45 = 3'd2,
      REG_KEY67 = 3'd3,
      REG_IV    = 3'd4,
      REG_MODE  = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              load;
      logic              round;
      logic              last;
      logic [KIDX_W-1:0] key_idx;
      logic              finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   typedef struct packed {
      logic [KEY_REGS-1:0][BLOCK_W-1:0] key;
      logic [BLOCK_W-1:0]               iv;
      logic                             decrypt;
   } csr_type;

   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
        4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7},
      '{4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
        4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8},
      '{4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
        4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11},
      '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
        4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
      '{4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
        4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2},
      '{4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
        4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8},
      '{4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
        4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11}
   };

   // Nibble k goes through row k.
   function automatic logic [HALF_W-1:0] gost_subst(input logic [HALF_W-1:0] s);
      logic [HALF_W-1:0] sub;
      sub = '0;
      for (int k = 0; k < 8; k++) begin
         sub[4*k +: 4] = SBOX[k][s[4*k +: 4]];
      end
      return sub;
   endfunction

   // Add key, substitute, rotate left.
   function automatic logic [HALF_W-1:0] gost_round_f(input logic [HALF_W-1:0] half,
                                                      input logic [HALF_W-1:0] kw);
      logic [HALF_W-1:0] sub;
      sub = gost_subst(half + kw);
      return {sub[HALF_W-ROT_BITS-1:0], sub[HALF_W-1:HALF_W-ROT_BITS]};
   endfunction

endpackage

>>> design/gcfb_if.sv
`timescale 1ns / 1ps

interface gcfb_req_if;
   logic                          valid;
   logic                          ready;
   logic [gcfb_pkg::BLOCK_W-1:0]  data_block;
   logic [gcfb_pkg::CNT_W-1:0]    valid_bytes;
   logic                          first_block;

   modport source (output valid, data_block, valid_bytes, first_block, input ready);
   modport sink   (input valid, data_block, valid_bytes, first_block, output ready);
endinterface

interface gcfb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gcfb_pkg::BLOCK_W-1:0]  result_block;

   modport source (output valid, result_block, input ready);
   modport sink   (input valid, result_block, output ready);
endinterface

>>> design/gcfb_csr.sv
`timescale 1ns / 1ps

module gcfb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gcfb_pkg::ADDR_W-1:0]  paddr,
   input  logic [gcfb_pkg::BLOCK_W-1:0] pwdata,
   output logic [gcfb_pkg::BLOCK_W-1:0] prdata,
   output gcfb_pkg::csr_type            csr
);
   import gcfb_pkg::*;

   csr_type     csr_ff;
   csr_type     csr_in;
   reg_idx_type sel;
   logic        wr_en;

   assign sel   = reg_idx_type'(paddr[ADDR_W-1:ADDR_W-REG_SEL_W]);
   assign wr_en = psel & penable & pwrite;
   assign csr   = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         unique case (sel)
            REG_KEY01: csr_in.key[0]  = pwdata;
            REG_KEY23: csr_in.key[1]  = pwdata;
            REG_KEY45: csr_in.key[2]  = pwdata;
            REG_KEY67: csr_in.key[3]  = pwdata;
            REG_IV:    csr_in.iv      = pwdata;
            REG_MODE:  csr_in.decrypt = pwdata[0];
            default:   csr_in         = csr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_KEY01: prdata = csr_ff.key[0];
         REG_KEY23: prdata = csr_ff.key[1];
         REG_KEY45: prdata = csr_ff.key[2];
         REG_KEY67: prdata = csr_ff.key[3];
         REG_IV:    prdata = csr_ff.iv;
         REG_MODE:  prdata = {{(BLOCK_W-1){1'b0}}, csr_ff.decrypt};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule

>>> design/gcfb_ctrl.sv
`timescale 1ns / 1ps

module gcfb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gcfb_pkg::dp_status_type   status,
   output gcfb_pkg::dp_cmd_type      cmd
);
   import gcfb_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [ROUND_W-1:0] round_ff;
   logic [ROUND_W-1:0] round_in;

   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      // Forward key order for the first rounds, reversed for the final eight.
      cmd.key_idx = (round_ff < ROUND_W'(REV_START)) ? round_ff[KIDX_W-1:0]
                                                     : ~round_ff[KIDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cmd.last  = (round_ff == ROUND_W'(ROUNDS - 1));
            if (cmd.last) begin
               state_in = ST_FINISH;
            end else begin
               round_in = round_ff + ROUND_W'(1);
            end
         end
         ST_FINISH: begin
            // Hold until the output register can take the result.
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

endmodule

>>> design/gcfb_dp.sv
`timescale 1ns / 1ps

module gcfb_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  gcfb_pkg::dp_cmd_type         cmd,
   output gcfb_pkg::dp_status_type      status,
   input  gcfb_pkg::csr_type            csr,
   input  logic [gcfb_pkg::BLOCK_W-1:0] req_data_block,
   input  logic [gcfb_pkg::CNT_W-1:0]   req_valid_bytes,
   input  logic                         req_first_block,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [gcfb_pkg::BLOCK_W-1:0] rsp_result_block
);
   import gcfb_pkg::*;

   logic [HALF_W-1:0]  n1_ff, n1_in;
   logic [HALF_W-1:0]  n2_ff, n2_in;
   logic [BLOCK_W-1:0] fb_ff, fb_in;
   logic [BLOCK_W-1:0] data_ff, data_in;
   logic [BYTES-1:0]   byte_en_ff, byte_en_in;
   logic [BLOCK_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [BLOCK_W-1:0] key_pair;
   logic [HALF_W-1:0]  key_word;
   logic [HALF_W-1:0]  t;
   logic [BLOCK_W-1:0] mask;
   logic [BLOCK_W-1:0] masked;
   logic [BLOCK_W-1:0] start_blk;

   assign key_pair = csr.key[cmd.key_idx[KIDX_W-1:1]];
   assign key_word = cmd.key_idx[0] ? key_pair[BLOCK_W-1:HALF_W] : key_pair[HALF_W-1:0];
   assign t        = n2_ff ^ gost_round_f(n1_ff, key_word);

   always_comb begin
      for (int i = 0; i < BYTES; i++) begin
         mask[8*i +: 8] = {8{byte_en_ff[i]}};
         byte_en_in[i]  = (req_valid_bytes > CNT_W'(i));
      end
   end

   assign masked    = ({n2_ff, n1_ff} ^ data_ff) & mask;
   assign start_blk = req_first_block ? csr.iv : fb_ff;

   always_comb begin
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      fb_in        = fb_ff;
      data_in      = data_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.load) begin
         n1_in   = start_blk[HALF_W-1:0];
         n2_in   = start_blk[BLOCK_W-1:HALF_W];
         fb_in   = start_blk;
         data_in = req_data_block;
      end
      if (cmd.round) begin
         if (cmd.last) begin
            n2_in = t;
         end else begin
            n2_in = n1_ff;
            n1_in = t;
         end
      end
      if (cmd.finish) begin
         res_in       = masked;
         rsp_valid_in = 1'b1;
         // Only a full block advances the feedback.
         if (&byte_en_ff) begin
            fb_in = csr.decrypt ? data_ff : masked;
         end
      end
   end

   assign status.out_busy  = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      data_ff <= data_in;
      res_ff  <= res_in;
      if (cmd.load) begin
         byte_en_ff <= byte_en_in;
      end
   end

endmodule

>>> design/gost_cfb_block_cipher.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload                                      | Transaction when
// req     | in        | data_block[63:0], valid_bytes[3:0], first    | req.valid & req.ready
// rsp     | out       | result_block[63:0]                           | rsp.valid & rsp.ready
// csr     | in (APB)  | paddr[5:0], pwdata[63:0], prdata[63:0]       | psel & penable & pwrite
//
// Each block goes through a load step on accept, 32 Feistel rounds through the single
// round unit, then a finish step that writes the output register; req is not ready
// again until the finish step is done. rsp valid is registered from the finish step.
// Reset is synchronous and active high; it clears the CSRs, the feedback block, rsp valid and
// the controller. A stalled rsp holds the finish step until the output register frees up;
// req stays ready while a finished result waits on rsp.

module gost_cfb_block_cipher (
   input  logic                         clock,
   input  logic                         reset,
   gcfb_req_if.sink                     req,
   gcfb_rsp_if.source                   rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gcfb_pkg::ADDR_W-1:0]  paddr,
   input  logic [gcfb_pkg::BLOCK_W-1:0] pwdata,
   output logic [gcfb_pkg::BLOCK_W-1:0] prdata,
   output logic                         pready
);
   import gcfb_pkg::*;

   csr_type       csr;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Zero-wait-state register port.
   assign pready = 1'b1;

   // Key words, IV and mode register file.
   gcfb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .csr     (csr)
   );

   // Sequencer: accept, step the round counter, finish into the output register.
   gcfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Feistel halves, feedback block, masking and the output register.
   gcfb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr              (csr),
      .req_data_block   (req.data_block),
      .req_valid_bytes  (req.valid_bytes),
      .req_first_block  (req.first_block),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_result_block (rsp.result_block)
   );

endmodule

>>> design/gcfb_checker.sv
`timescale 1ns / 1ps
`include "gost_cfb_block_cipher_macros.svh"

module gcfb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gcfb_pkg::BLOCK_W-1:0] rsp_result_block
);

   // After a transaction on req, the block is busy and req ready stays low.
   `GCFB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready ##1 !req_ready, "req ready too soon after a transaction")

   // Ready drops only because a transaction was taken.
   `GCFB_ASSERT_IMPL(a_ready_drop_cause, $fell(req_ready), $past(req_valid), "req ready fell without a transaction")

   // A new result appears together with readiness for the next block.
   `GCFB_ASSERT_IMPL(a_result_frees_input, $rose(rsp_valid), req_ready, "result shown while input still busy")

   // A stalled result holds.
   `GCFB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_block), "stalled result changed")

endmodule

bind gost_cfb_block_cipher gcfb_checker u_gcfb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_result_block (rsp.result_block)
);
